>>> design/avm_pkg.sv
package avm_pkg;

	localparam int RAW_W        = 16;
	localparam int PROD_W       = 27;
	localparam int MG_W         = 12;
	localparam int MAG_W        = 11;
	localparam int SQ_W         = 22;
	localparam int SUM_W        = 24;
	localparam int REM_W        = 16;
	localparam int ROOT_W       = 12;
	localparam int FULL_SCALE_MG = 2000;
	localparam int COUNT_SHIFT  = 15;
	localparam int COUNT_SPAN   = 1 << COUNT_SHIFT;
	localparam int STEPS_PER_STAGE = 3;
	localparam int ROOT_STAGES  = ROOT_W / STEPS_PER_STAGE;
	localparam int MAG_MAX_MG   = 3464;

	typedef struct packed {
		logic [SUM_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_state_t;

endpackage

>>> design/avm_axis.sv
module avm_axis (
	input  logic                                clk,
	input  logic                                en_s1,
	input  logic                                en_s2,
	input  logic signed [avm_pkg::RAW_W-1:0]    raw,
	output logic        [avm_pkg::SQ_W-1:0]     sq_s2
);

	logic signed [avm_pkg::PROD_W-1:0] prod;
	logic signed [avm_pkg::PROD_W-1:0] biased;
	logic signed [avm_pkg::MG_W-1:0]   mg;
	logic        [avm_pkg::MG_W-1:0]   mg_abs;
	logic        [avm_pkg::MAG_W-1:0]  mag_s1;

	always_comb begin
		prod   = $signed({{(avm_pkg::PROD_W-avm_pkg::RAW_W){raw[avm_pkg::RAW_W-1]}}, raw})
			* $signed(avm_pkg::PROD_W'(avm_pkg::FULL_SCALE_MG));
		// round toward zero for negative products
		biased = prod + (prod[avm_pkg::PROD_W-1] ?
			$signed(avm_pkg::PROD_W'(avm_pkg::COUNT_SPAN - 1)) : $signed(avm_pkg::PROD_W'(0)));
		mg     = biased[avm_pkg::PROD_W-1:avm_pkg::COUNT_SHIFT];
		mg_abs = mg[avm_pkg::MG_W-1] ? avm_pkg::MG_W'(-mg) : avm_pkg::MG_W'(mg);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mag_s1 <= mg_abs[avm_pkg::MAG_W-1:0];
		end
		if (en_s2) begin
			sq_s2 <= avm_pkg::SQ_W'(mag_s1) * avm_pkg::SQ_W'(mag_s1);
		end
	end

endmodule

>>> design/avm_root_step.sv
module avm_root_step (
	input  avm_pkg::root_state_t st_in,
	output avm_pkg::root_state_t st_out
);

	always_comb begin
		logic [avm_pkg::REM_W-1:0] r;
		logic [avm_pkg::REM_W-1:0] trial;
		st_out = st_in;
		for (int i = 0; i < avm_pkg::STEPS_PER_STAGE; i++) begin
			r     = {st_out.rem[avm_pkg::REM_W-3:0],
				st_out.rad[avm_pkg::SUM_W-1:avm_pkg::SUM_W-2]};
			trial = avm_pkg::REM_W'({st_out.root, 2'b01});
			st_out.rad = {st_out.rad[avm_pkg::SUM_W-3:0], 2'b00};
			if (r >= trial) begin
				st_out.rem  = r - trial;
				st_out.root = {st_out.root[avm_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				st_out.rem  = r;
				st_out.root = {st_out.root[avm_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

endmodule

>>> design/accel_vector_magnitude.sv
// Vector magnitude in milli-g of one three-axis accelerometer sample (2 g full scale):
// each axis is scaled to mg, squared, summed, and the floor square root is returned.
// Seven pipeline stages: scale, square, sum, then four square-root stages of three
// result bits each. One item is taken every cycle while the output is not stalled.
// Each stage holds its item when the stage after it is full and stalled, so the input
// side keeps taking items while any stage still has room.
module accel_vector_magnitude (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [avm_pkg::RAW_W-1:0]    accel_x_raw,
	input  logic signed [avm_pkg::RAW_W-1:0]    accel_y_raw,
	input  logic signed [avm_pkg::RAW_W-1:0]    accel_z_raw,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [avm_pkg::ROOT_W-1:0]   magnitude_mg
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	logic [avm_pkg::SQ_W-1:0]  sqx_s2, sqy_s2, sqz_s2;
	logic [avm_pkg::SUM_W-1:0] sum_s3;

	avm_pkg::root_state_t st_s4, st_s5, st_s6, st_s7;
	avm_pkg::root_state_t st_in4, nx4, nx5, nx6, nx7;

	assign rdy7 = !vld_s7 || out_ready;
	assign rdy6 = !vld_s6 || rdy7;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign in_ready     = rdy1;
	assign out_valid    = vld_s7;
	assign magnitude_mg = st_s7.root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
			if (rdy7) vld_s7 <= vld_s6;
		end
	end

	avm_axis u_axis_x (.clk(clk), .en_s1(rdy1), .en_s2(rdy2), .raw(accel_x_raw), .sq_s2(sqx_s2));
	avm_axis u_axis_y (.clk(clk), .en_s1(rdy1), .en_s2(rdy2), .raw(accel_y_raw), .sq_s2(sqy_s2));
	avm_axis u_axis_z (.clk(clk), .en_s1(rdy1), .en_s2(rdy2), .raw(accel_z_raw), .sq_s2(sqz_s2));

	always_comb begin
		st_in4.rad  = sum_s3;
		st_in4.rem  = '0;
		st_in4.root = '0;
	end

	avm_root_step u_step4 (.st_in(st_in4), .st_out(nx4));
	avm_root_step u_step5 (.st_in(st_s4),  .st_out(nx5));
	avm_root_step u_step6 (.st_in(st_s5),  .st_out(nx6));
	avm_root_step u_step7 (.st_in(st_s6),  .st_out(nx7));

	always_ff @(posedge clk) begin
		if (rdy3) sum_s3 <= avm_pkg::SUM_W'(sqx_s2) + avm_pkg::SUM_W'(sqy_s2)
			+ avm_pkg::SUM_W'(sqz_s2);
		if (rdy4) st_s4 <= nx4;
		if (rdy5) st_s5 <= nx5;
		if (rdy6) st_s6 <= nx6;
		if (rdy7) st_s7 <= nx7;
	end

endmodule

>>> design/avm_checker.sv
module avm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [avm_pkg::ROOT_W-1:0]        magnitude_mg
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(magnitude_mg))
		else $error("result dropped or changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> magnitude_mg <= avm_pkg::ROOT_W'(avm_pkg::MAG_MAX_MG))
		else $error("magnitude out of range");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is taken");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input item dropped while stalled");

endmodule

bind accel_vector_magnitude avm_checker u_avm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.magnitude_mg(magnitude_mg)
);

>>> sim/accel_vector_magnitude_checker.sv
module accel_vector_magnitude_checker
	import avm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [RAW_W-1:0]  accel_x_raw,
	input  logic signed [RAW_W-1:0]  accel_y_raw,
	input  logic signed [RAW_W-1:0]  accel_z_raw,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic        [ROOT_W-1:0] magnitude_mg,
	output int                       errors,
	output int                       pending
);

	typedef struct {
		logic signed [RAW_W-1:0] x;
		logic signed [RAW_W-1:0] y;
		logic signed [RAW_W-1:0] z;
		logic [ROOT_W-1:0]       mag;
	} sample_mag_t;

	sample_mag_t mag_due[$];

	function automatic int axis_mg(input logic signed [RAW_W-1:0] raw);
		int v;
		v = raw;
		// int division truncates toward zero
		return (v * FULL_SCALE_MG) / COUNT_SPAN;
	endfunction

	function automatic logic [ROOT_W-1:0] floor_root(input int unsigned n);
		int unsigned rem;
		int unsigned root;
		int unsigned pair_bit;
		rem      = n;
		root     = 0;
		pair_bit = 32'h4000_0000;
		while (pair_bit > rem)
			pair_bit >>= 2;
		while (pair_bit != 0) begin
			if (rem >= root + pair_bit) begin
				rem  = rem - (root + pair_bit);
				root = (root >> 1) + pair_bit;
			end else begin
				root >>= 1;
			end
			pair_bit >>= 2;
		end
		return root[ROOT_W-1:0];
	endfunction

	function automatic logic [ROOT_W-1:0] magnitude_of(
		input logic signed [RAW_W-1:0] x,
		input logic signed [RAW_W-1:0] y,
		input logic signed [RAW_W-1:0] z
	);
		int          xm;
		int          ym;
		int          zm;
		int unsigned sum;
		xm  = axis_mg(x);
		ym  = axis_mg(y);
		zm  = axis_mg(z);
		sum = xm * xm + ym * ym + zm * zm;
		return floor_root(sum);
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin
		sample_mag_t due;
		sample_mag_t fresh;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (mag_due.size() == 0) begin
					report_mismatch($sformatf("magnitude_mg %0d with no item pending",
						magnitude_mg));
				end else begin
					due = mag_due.pop_front();
					if (magnitude_mg !== due.mag)
						report_mismatch($sformatf(
							"x %0d y %0d z %0d: magnitude_mg %0d, want %0d",
							due.x, due.y, due.z, magnitude_mg, due.mag));
				end
			end
			if (in_valid && in_ready) begin
				fresh.x   = accel_x_raw;
				fresh.y   = accel_y_raw;
				fresh.z   = accel_z_raw;
				fresh.mag = magnitude_of(accel_x_raw, accel_y_raw, accel_z_raw);
				mag_due.push_back(fresh);
			end
			pending = mag_due.size();
		end
	end

endmodule

>>> sim/accel_vector_magnitude_tb.sv
module accel_vector_magnitude_tb;
	import avm_pkg::*;

	localparam int ITEMS_PER_PHASE = 200;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int SETTLE_CYCLES   = 20;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [RAW_W-1:0] accel_x_raw;
	logic signed [RAW_W-1:0] accel_y_raw;
	logic signed [RAW_W-1:0] accel_z_raw;
	logic                    out_valid;
	logic                    out_ready;
	logic [ROOT_W-1:0]       magnitude_mg;

	int idle_pct;
	int stall_pct;
	int errors;
	int pending;
	int cycles;

	int idle_by_phase[4]  = '{0, 47, 0, 38};
	int stall_by_phase[4] = '{0, 0, 47, 38};

	accel_vector_magnitude u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.accel_x_raw  (accel_x_raw),
		.accel_y_raw  (accel_y_raw),
		.accel_z_raw  (accel_z_raw),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.magnitude_mg (magnitude_mg)
	);

	accel_vector_magnitude_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.accel_x_raw  (accel_x_raw),
		.accel_y_raw  (accel_y_raw),
		.accel_z_raw  (accel_z_raw),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.magnitude_mg (magnitude_mg),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic signed [RAW_W-1:0] random_axis();
		logic signed [RAW_W-1:0] picks[9] = '{-32768, 32767, -1, 0, 1, -16, -17, 16, 17};
		case ($urandom_range(9))
			6, 7:    return RAW_W'($signed($urandom_range(80)) - 40);
			8:       return picks[$urandom_range(8)];
			default: return RAW_W'($urandom());
		endcase
	endfunction

	// enter and leave at a falling edge
	task automatic send_sample(
		input logic signed [RAW_W-1:0] x,
		input logic signed [RAW_W-1:0] y,
		input logic signed [RAW_W-1:0] z
	);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		accel_x_raw <= x;
		accel_y_raw <= y;
		accel_z_raw <= z;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		accel_x_raw = '0;
		accel_y_raw = '0;
		accel_z_raw = '0;
		idle_pct    = idle_by_phase[0];
		stall_pct   = stall_by_phase[0];
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_sample(0, 0, 0);
		send_sample(32767, 32767, 32767);
		send_sample(-32768, -32768, -32768);
		send_sample(-32768, 0, 0);
		send_sample(0, -32768, 0);
		send_sample(0, 0, -32768);
		send_sample(32767, 0, 0);
		send_sample(0, 32767, 0);
		send_sample(0, 0, 32767);
		send_sample(-1, -1, -1);
		send_sample(-16, -16, -16);
		send_sample(-17, -17, -17);
		send_sample(16, 17, -17);
		send_sample(1, 1, 1);
		send_sample(32767, -32768, 32767);
		send_sample(-32768, 32767, -32768);
		send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
		send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);
		send_sample(16384, 16384, 16384);
		send_sample(19661, 26214, 0);
		send_sample(-19661, -26214, -32768);

		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_by_phase[p];
			stall_pct = stall_by_phase[p];
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_sample(random_axis(), random_axis(), random_axis());
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
